### src/fqks_pkg.sv
// Shared types and codes for the FIFO queue with key search.
// Used by fqks_cell and fifo_queue_with_key_search; depends on nothing.
package fqks_pkg;

  localparam int OP_W  = 2;
  localparam int VAL_W = 32;
  localparam int ST_W  = 3;
  localparam int POS_W = 5;

  // Request codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;
  localparam logic [OP_W-1:0] OP_LIST   = 2'd3;

  // Result status codes
  localparam logic [ST_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [ST_W-1:0] ST_REMOVED  = 3'd1;
  localparam logic [ST_W-1:0] ST_FOUND    = 3'd2;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd4;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd5;
  localparam logic [ST_W-1:0] ST_LISTED   = 3'd6;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FIN
  } state_t;

  // Per-cell control: shift takes the neighbor's value, load takes the shared bus
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

### src/fqks_cell.sv
// One storage cell of the queue chain: holds one entry and hands it to its
// neighbor toward the front. Depends on fqks_pkg.
module fqks_cell (
  input  logic                         clk,
  input  fqks_pkg::cell_ctrl_t         ctrl,
  input  logic [fqks_pkg::VAL_W-1:0]   load_data,
  input  logic [fqks_pkg::VAL_W-1:0]   nbr_data,
  output logic [fqks_pkg::VAL_W-1:0]   data_o
);

  logic [fqks_pkg::VAL_W-1:0] data_r;
  logic [fqks_pkg::VAL_W-1:0] data_nxt;

  // Load wins over shift so the rotating front value lands at the rear
  always_comb begin
    data_nxt = data_r;
    if (ctrl.load) begin
      data_nxt = load_data;
    end else if (ctrl.shift) begin
      data_nxt = nbr_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

endmodule

### src/fifo_queue_with_key_search.sv
// Top level of the FIFO queue with key search: control sequencer, output
// register and the chain of fqks_cell entries. Depends on fqks_pkg, fqks_cell.
//
// The queue is a row of DEPTH cells with the front entry always in cell 0.
// Insert writes the cell at the fill count index, just past the occupied
// cells; remove shifts the whole row one cell toward the front. Search
// and read-out rotate the occupied cells once: each cycle the front entry is
// examined and written back at the rear, unless the result register is held
// by out_tready low; the walk then ends in a closing state that issues the
// last result. Every request yields at least one result; results carry
// tlast on the final one. One request is in work at a time.
module fifo_queue_with_key_search #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [1:0] operation, [33:2] value, [39:34] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [2:0] status, [34:3] item_value, [39:35] position
  output logic        out_tlast
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PX = CW + fqks_pkg::POS_W;

  // Request fields
  logic [fqks_pkg::OP_W-1:0]  in_op;
  logic [fqks_pkg::VAL_W-1:0] in_val;
  assign in_op  = in_tdata[1:0];
  assign in_val = in_tdata[33:2];

  // Cell chain
  logic [fqks_pkg::VAL_W-1:0] cell_q [DEPTH];
  fqks_pkg::cell_ctrl_t       cell_ctrl [DEPTH];
  logic                       shift_en;
  logic                       ld_en;
  logic [CW-1:0]              ld_idx;
  logic [fqks_pkg::VAL_W-1:0] ld_data;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [fqks_pkg::VAL_W-1:0] nbr;
    if (g < DEPTH - 1) begin : g_mid
      assign nbr = cell_q[g+1];
    end else begin : g_end
      assign nbr = cell_q[g];
    end
    assign cell_ctrl[g].shift = shift_en;
    assign cell_ctrl[g].load  = ld_en && (ld_idx == CW'(g));
    fqks_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl[g]),
      .load_data (ld_data),
      .nbr_data  (nbr),
      .data_o    (cell_q[g])
    );
  end

  // Control and output registers
  fqks_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]              occ_r, occ_nxt;
  logic [CW-1:0]              step_r, step_nxt;
  logic [fqks_pkg::OP_W-1:0]  op_r, op_nxt;
  logic [fqks_pkg::VAL_W-1:0] key_r, key_nxt;
  logic                       hold_valid_r, hold_valid_nxt;
  logic [fqks_pkg::VAL_W-1:0] hold_val_r, hold_val_nxt;
  logic [fqks_pkg::POS_W-1:0] hold_pos_r, hold_pos_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [fqks_pkg::ST_W-1:0]  out_status_r, out_status_nxt;
  logic [fqks_pkg::VAL_W-1:0] out_val_r, out_val_nxt;
  logic [fqks_pkg::POS_W-1:0] out_pos_r, out_pos_nxt;
  logic                       out_last_r, out_last_nxt;

  logic                       out_free;
  logic                       match;
  logic [PX-1:0]              pos_ext;
  logic [fqks_pkg::POS_W-1:0] pos_now;
  logic [fqks_pkg::ST_W-1:0]  walk_status;

  assign out_free    = !out_valid_r || out_tready;
  assign in_tready   = (state_r == fqks_pkg::S_IDLE) && out_free;
  assign match       = (op_r == fqks_pkg::OP_LIST) || (cell_q[0] == key_r);
  assign pos_ext     = PX'(step_r) + PX'(1);
  assign pos_now     = pos_ext[fqks_pkg::POS_W-1:0];
  assign walk_status = (op_r == fqks_pkg::OP_LIST) ? fqks_pkg::ST_LISTED
                                                   : fqks_pkg::ST_FOUND;

  always_comb begin
    state_nxt      = state_r;
    occ_nxt        = occ_r;
    step_nxt       = step_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    hold_valid_nxt = hold_valid_r;
    hold_val_nxt   = hold_val_r;
    hold_pos_nxt   = hold_pos_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_val_nxt    = out_val_r;
    out_pos_nxt    = out_pos_r;
    out_last_nxt   = out_last_r;
    shift_en       = 1'b0;
    ld_en          = 1'b0;
    ld_idx         = occ_r;
    ld_data        = in_val;

    case (state_r)
      fqks_pkg::S_IDLE: begin
        if (in_tvalid && in_tready) begin
          out_valid_nxt  = 1'b1;
          out_val_nxt    = '0;
          out_pos_nxt    = '0;
          out_last_nxt   = 1'b1;
          out_status_nxt = fqks_pkg::ST_EMPTY;
          case (in_op)
            fqks_pkg::OP_INSERT: begin
              if (occ_r == CW'(DEPTH)) begin
                out_status_nxt = fqks_pkg::ST_FULL;
              end else begin
                ld_en          = 1'b1;
                occ_nxt        = occ_r + CW'(1);
                out_status_nxt = fqks_pkg::ST_INSERTED;
              end
            end
            fqks_pkg::OP_REMOVE: begin
              if (occ_r != '0) begin
                shift_en       = 1'b1;
                occ_nxt        = occ_r - CW'(1);
                out_status_nxt = fqks_pkg::ST_REMOVED;
                out_val_nxt    = cell_q[0];
              end
            end
            default: begin
              // search and read-out: start a walk unless empty
              if (occ_r != '0) begin
                out_valid_nxt  = out_valid_r && !out_tready;
                out_status_nxt = out_status_r;
                out_val_nxt    = out_val_r;
                out_pos_nxt    = out_pos_r;
                out_last_nxt   = out_last_r;
                op_nxt         = in_op;
                key_nxt        = in_val;
                step_nxt       = '0;
                hold_valid_nxt = 1'b0;
                state_nxt      = fqks_pkg::S_WALK;
              end
            end
          endcase
        end
      end
      fqks_pkg::S_WALK: begin
        if (out_free) begin
          // rotate: front goes out for compare and back in at the rear
          shift_en = 1'b1;
          ld_en    = 1'b1;
          ld_idx   = occ_r - CW'(1);
          ld_data  = cell_q[0];
          if (match) begin
            if (hold_valid_r) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = walk_status;
              out_val_nxt    = hold_val_r;
              out_pos_nxt    = hold_pos_r;
              out_last_nxt   = 1'b0;
            end
            hold_valid_nxt = 1'b1;
            hold_val_nxt   = cell_q[0];
            hold_pos_nxt   = pos_now;
          end
          if (step_r == occ_r - CW'(1)) begin
            state_nxt = fqks_pkg::S_FIN;
          end else begin
            step_nxt = step_r + CW'(1);
          end
        end
      end
      fqks_pkg::S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          if (hold_valid_r) begin
            out_status_nxt = walk_status;
            out_val_nxt    = hold_val_r;
            out_pos_nxt    = hold_pos_r;
          end else begin
            out_status_nxt = fqks_pkg::ST_NOTFOUND;
            out_val_nxt    = '0;
            out_pos_nxt    = '0;
          end
          hold_valid_nxt = 1'b0;
          state_nxt      = fqks_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = fqks_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= fqks_pkg::S_IDLE;
      occ_r        <= '0;
      step_r       <= '0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      occ_r        <= occ_nxt;
      step_r       <= step_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    hold_val_r   <= hold_val_nxt;
    hold_pos_r   <= hold_pos_nxt;
    out_status_r <= out_status_nxt;
    out_val_r    <= out_val_nxt;
    out_pos_r    <= out_pos_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_pos_r, out_val_r, out_status_r};
  assign out_tlast  = out_last_r;

`ifndef SYNTH
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CW'(DEPTH))
    else $error("occupancy exceeds depth");

  a_walk_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fqks_pkg::S_WALK) |-> (step_r < occ_r))
    else $error("walk step beyond fill count");

  a_walk_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fqks_pkg::S_WALK) |=> $stable(occ_r))
    else $error("fill count changed during walk");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != fqks_pkg::S_IDLE) |-> !in_tready)
    else $error("request accepted while walking");
`endif

endmodule

### bench/fqks_queue_checker.sv
// Checker for the FIFO queue with key search: watches both stream channels,
// predicts the results of each request and compares them. Depends on fqks_pkg.
module fqks_queue_checker #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,   // [1:0] operation, [33:2] value, [39:34] zero
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,  // [2:0] status, [34:3] item_value, [39:35] position
  input  logic        out_tlast,
  output int          fail_count,
  output int          outstanding
);

  localparam int VW = fqks_pkg::VAL_W;
  localparam int PW = fqks_pkg::POS_W;

  typedef struct {
    logic [fqks_pkg::ST_W-1:0]  status;
    logic [fqks_pkg::VAL_W-1:0] item_value;
    logic [fqks_pkg::POS_W-1:0] position;
    logic                       last;
  } queue_result_t;

  queue_result_t              expected_results[$];
  logic [fqks_pkg::VAL_W-1:0] slots[DEPTH];
  int                         front_idx;
  int                         rear_idx;
  int                         fill;

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string what, input logic [fqks_pkg::VAL_W-1:0] seen,
                                 input logic [fqks_pkg::VAL_W-1:0] want);
    fail_count++;
    $display("mismatch at %0t: %s got %h expected %h", $time, what, seen, want);
  endtask

  function automatic void add_expected(input logic [fqks_pkg::ST_W-1:0] status,
                                       input logic [fqks_pkg::VAL_W-1:0] item_value,
                                       input logic [fqks_pkg::POS_W-1:0] position,
                                       input logic last);
    queue_result_t r;
    r.status     = status;
    r.item_value = item_value;
    r.position   = position;
    r.last       = last;
    expected_results.push_back(r);
  endfunction

  // Update the queue model with one request and queue up its results
  task automatic apply_request(input logic [fqks_pkg::OP_W-1:0] op,
                               input logic [fqks_pkg::VAL_W-1:0] key);
    int idx;
    int hits;
    if (op == fqks_pkg::OP_INSERT) begin
      if (fill >= DEPTH) begin
        add_expected(fqks_pkg::ST_FULL, '0, '0, 1'b1);
      end else begin
        slots[rear_idx] = key;
        rear_idx = (rear_idx + 1) % DEPTH;
        fill++;
        add_expected(fqks_pkg::ST_INSERTED, '0, '0, 1'b1);
      end
    end else if (fill == 0) begin
      add_expected(fqks_pkg::ST_EMPTY, '0, '0, 1'b1);
    end else if (op == fqks_pkg::OP_REMOVE) begin
      add_expected(fqks_pkg::ST_REMOVED, slots[front_idx], '0, 1'b1);
      front_idx = (front_idx + 1) % DEPTH;
      fill--;
    end else begin
      hits = 0;
      idx  = front_idx;
      for (int i = 0; i < fill; i++) begin
        if (op == fqks_pkg::OP_LIST) begin
          add_expected(fqks_pkg::ST_LISTED, slots[idx], PW'(i + 1), 1'b0);
          hits++;
        end else if (slots[idx] == key) begin
          add_expected(fqks_pkg::ST_FOUND, key, PW'(i + 1), 1'b0);
          hits++;
        end
        idx = (idx + 1) % DEPTH;
      end
      if (hits == 0) begin
        add_expected(fqks_pkg::ST_NOTFOUND, '0, '0, 1'b1);
      end else begin
        expected_results[$].last = 1'b1;
      end
    end
  endtask

  always @(posedge clk) begin
    queue_result_t want;
    if (!rst_n) begin
      front_idx = 0;
      rear_idx  = 0;
      fill      = 0;
      expected_results.delete();
    end else begin
      // Results always belong to requests taken at earlier edges, so check first
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, tdata", out_tdata[VW-1:0], '0);
        end else begin
          want = expected_results.pop_front();
          if (out_tdata[2:0] !== want.status)
            report_mismatch("status", VW'(out_tdata[2:0]), VW'(want.status));
          if (out_tdata[34:3] !== want.item_value)
            report_mismatch("item_value", out_tdata[34:3], want.item_value);
          if (out_tdata[39:35] !== want.position)
            report_mismatch("position", VW'(out_tdata[39:35]), VW'(want.position));
          if (out_tlast !== want.last)
            report_mismatch("tlast", VW'(out_tlast), VW'(want.last));
        end
      end
      if (in_tvalid && in_tready) begin
        apply_request(in_tdata[1:0], in_tdata[33:2]);
      end
    end
    outstanding = expected_results.size();
  end

endmodule

### bench/fifo_queue_with_key_search_test.sv
// Testbench top for the FIFO queue with key search: clock, reset, request and
// result stream drivers, verdict. Depends on fqks_pkg, fqks_queue_checker, the block.
module fifo_queue_with_key_search_test;

  localparam int DEPTH       = 16;
  localparam int RANDOM_REQS = 450;
  localparam int CALM_FROM   = 390;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tlast;

  int fail_count;
  int outstanding;
  int sent_count  = 0;
  int cycle_count = 0;
  bit calm        = 1'b0;
  bit held_once   = 1'b0;

  always #5 clk = ~clk;

  fifo_queue_with_key_search #(.DEPTH(DEPTH)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  fqks_queue_checker #(.DEPTH(DEPTH)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Offer one request and hold it until the block takes it
  task automatic send_request(input logic [fqks_pkg::OP_W-1:0] op,
                              input logic [fqks_pkg::VAL_W-1:0] value);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, value, op};
    do @(posedge clk); while (!in_tready);
    sent_count++;
  endtask

  // Favor a few repeated keys so searches hit, often more than once
  function automatic logic [fqks_pkg::VAL_W-1:0] pick_value();
    if ($urandom_range(0, 1) == 0) return $urandom;
    case ($urandom_range(0, 4))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return 32'h0000_0005;
    endcase
  endfunction

  // Phases: balanced, fill toward full, look-ups, drain toward empty
  function automatic logic [fqks_pkg::OP_W-1:0] pick_op(input int phase);
    int roll;
    int ins_lim;
    int rem_lim;
    int srch_lim;
    roll = $urandom_range(0, 99);
    case (phase)
      0:       begin ins_lim = 40; rem_lim = 65; srch_lim = 85; end
      1:       begin ins_lim = 75; rem_lim = 82; srch_lim = 94; end
      2:       begin ins_lim = 30; rem_lim = 40; srch_lim = 80; end
      default: begin ins_lim = 20; rem_lim = 75; srch_lim = 90; end
    endcase
    if (roll < ins_lim) return fqks_pkg::OP_INSERT;
    if (roll < rem_lim) return fqks_pkg::OP_REMOVE;
    if (roll < srch_lim) return fqks_pkg::OP_SEARCH;
    return fqks_pkg::OP_LIST;
  endfunction

  // Result side: random stall bursts, one long hold-off, none near the end
  initial begin
    out_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (rst_n && !held_once && sent_count >= 150) begin
        held_once = 1'b1;
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        out_tready <= 1'b1;
      end else if (rst_n && !calm && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty queue answers
    send_request(fqks_pkg::OP_REMOVE, 32'h0000_0001);
    send_request(fqks_pkg::OP_SEARCH, 32'h0000_0000);
    send_request(fqks_pkg::OP_LIST,   32'hFFFF_FFFF);
    // Extreme values, a duplicate key
    send_request(fqks_pkg::OP_INSERT, 32'h8000_0000);
    send_request(fqks_pkg::OP_INSERT, 32'h7FFF_FFFF);
    send_request(fqks_pkg::OP_INSERT, 32'h0000_0000);
    send_request(fqks_pkg::OP_INSERT, 32'hFFFF_FFFF);
    send_request(fqks_pkg::OP_INSERT, 32'h7FFF_FFFF);
    send_request(fqks_pkg::OP_SEARCH, 32'h7FFF_FFFF);
    send_request(fqks_pkg::OP_SEARCH, 32'h8000_0000);
    send_request(fqks_pkg::OP_SEARCH, 32'h0000_0005);
    send_request(fqks_pkg::OP_LIST,   32'h0000_0000);
    send_request(fqks_pkg::OP_REMOVE, 32'h0000_0000);
    send_request(fqks_pkg::OP_REMOVE, 32'h0000_0000);
    send_request(fqks_pkg::OP_SEARCH, 32'h7FFF_FFFF);
    send_request(fqks_pkg::OP_LIST,   32'h0000_0000);

    for (int i = 0; i < RANDOM_REQS; i++) begin
      calm = (i >= CALM_FROM);
      send_request(pick_op((i / 40) % 4), pick_value());
    end
    in_tvalid <= 1'b0;
    @(posedge clk);

    while (outstanding != 0) @(posedge clk);
    repeat (DEPTH + 4) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### sim.f
src/fqks_pkg.sv
src/fqks_cell.sv
src/fifo_queue_with_key_search.sv
bench/fqks_queue_checker.sv
bench/fifo_queue_with_key_search_test.sv
